// File: rtl/hde_pkg.sv
// hde_pkg: shared types and constants for the histogram density estimator
`default_nettype none
package hde_pkg;

    localparam int SMP_W        = 32;  // Q16.16 sample width
    localparam int K_W          = 7;   // bin count register width
    localparam int BIN_W        = 6;   // reported bin index width
    localparam int WIDE_W       = 33;  // widened range width
    localparam int BQ_W         = 7;   // quotient bits of a binning divide
    localparam int FRAC_W       = 32;  // fraction shift of the density
    localparam int WIDEN_SHIFT  = 20;  // range widening shift

    localparam logic [K_W-1:0]   K_RESET = 7'd16;
    localparam logic [SMP_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0] MIN_NEG = 32'h8000_0000;
    localparam logic [SMP_W-1:0] DENS_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_value;
        logic                    last_sample;
    } in_beat_t;

    typedef struct packed {
        logic [BIN_W-1:0]        bin_number;
        logic signed [SMP_W-1:0] bin_low_edge;
        logic [SMP_W-1:0]        bin_density;
        logic                    zero_range;
        logic                    last_bin;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_S_RD,
        ST_S_MUL,
        ST_S_GO,
        ST_S_WAIT,
        ST_T_RD,
        ST_T_WR,
        ST_E_MUL,
        ST_E_GO,
        ST_E_WAIT,
        ST_D_MUL,
        ST_D_GO,
        ST_D_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic pass_init;
        logic smp_rd;
        logic bin_mul;
        logic tally_rd_bin;
        logic tally_wr;
        logic next_smp;
        logic edge_mul;
        logic dens_mul;
        logic div_start;
        logic div_short;
        logic out_load;
        logic next_bin;
        logic pass_end;
    } dp_cmd_t;

    typedef struct packed {
        logic in_last;
        logic div_busy;
        logic div_done;
        logic smp_last;
        logic bin_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/hde_div.sv
// hde_div: restoring divider, one quotient bit per cycle
`default_nettype none
module hde_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 44
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             short_mode,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import hde_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= short_mode ? CW'(BQ_W) : CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            quot_reg <= '0;
            if (short_mode)
            begin
                // quotient known to fit in the low bits: skip the leading zeros
                rem_reg <= DEN_W'(num >> BQ_W);
                num_reg <= num << (NUM_W - BQ_W);
            end
            else
            begin
                rem_reg <= '0;
                num_reg <= num;
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
            num_reg  <= num_reg << 1;
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = quot_reg;

endmodule
`default_nettype wire

// File: rtl/hde_datapath.sv
// hde_datapath: sample store, range tracking, bin tallies, divider and output register
`default_nettype none
module hde_datapath #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_BINS    = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hde_pkg::dp_cmd_t            cmd,
    output hde_pkg::dp_status_t         status,
    input  hde_pkg::in_beat_t           in_beat,
    input  logic                        cfg_write_en,
    input  logic [hde_pkg::K_W-1:0]     cfg_write_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output hde_pkg::out_beat_t          out_beat
);
    import hde_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int TB_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NUM_W = CNT_W + K_W + FRAC_W;
    localparam int DEN_W = CNT_W + WIDE_W;

    // set state
    logic [CNT_W-1:0]        total_reg;
    logic signed [SMP_W-1:0] min_reg;
    logic signed [SMP_W-1:0] max_reg;
    logic [K_W-1:0]          bin_count_reg;

    // pass state
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic [WIDE_W-1:0] wide_reg;
    logic [WIDE_W-1:0] wide_next;
    logic              zr_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [TB_W-1:0]   i_reg;
    logic [TB_W-1:0]   m_reg;
    logic [TB_W-1:0]   m_next;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic signed [SMP_W-1:0] edge_reg;
    logic signed [SMP_W-1:0] edge_next;

    logic              out_valid_reg;
    out_beat_t         out_beat_reg;

    // memories
    logic [SMP_W-1:0]  smp_mem [MAX_SAMPLES];
    logic signed [SMP_W-1:0] smp_rd_reg;
    logic [CNT_W-1:0]  tally_mem [MAX_BINS];
    logic [MAX_BINS-1:0] tally_vld_reg;
    logic [CNT_W-1:0]  tally_q_reg;
    logic [TB_W-1:0]   tally_addr;
    logic              tally_rd;

    logic              store_we;
    logic signed [SMP_W:0]   diff;
    logic [SMP_W-1:0]        range;
    logic [WIDE_W-1:0]       offset;
    logic [WIDE_W+K_W-1:0]   bin_prod;
    logic [WIDE_W+TB_W-1:0]  edge_prod;
    logic [CNT_W+K_W-1:0]    tk_prod;
    logic [DEN_W-1:0]        nw_prod;
    logic signed [SMP_W+2:0] edge_sum;
    logic [SMP_W-1:0]        dens_next;
    logic [BQ_W-1:0]         q_bin;

    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    hde_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .short_mode (cmd.div_short),
        .num        (num_reg),
        .den        (den_reg),
        .busy       (div_busy),
        .done       (div_done),
        .quot       (div_quot)
    );

    assign store_we = cmd.accept && (total_reg < CNT_W'(MAX_SAMPLES));

    // range and bin count for the pass
    assign diff      = {max_reg[SMP_W-1], max_reg} - {min_reg[SMP_W-1], min_reg};
    assign range     = ((total_reg != '0) && (max_reg > min_reg)) ? diff[SMP_W-1:0] : '0;
    assign wide_next = {1'b0, range} + WIDE_W'(range >> WIDEN_SHIFT);

    always_comb
    begin
        priority if (bin_count_reg == '0)
            k_next = K_W'(1);
        else if (bin_count_reg > K_W'(MAX_BINS))
            k_next = K_W'(MAX_BINS);
        else
            k_next = bin_count_reg;
    end

    // products, each registered before the divider takes them
    assign offset    = WIDE_W'({smp_rd_reg[SMP_W-1], smp_rd_reg} -
                               {min_reg[SMP_W-1], min_reg});
    assign bin_prod  = offset * k_reg;
    assign edge_prod = wide_reg * i_reg;
    assign tk_prod   = tally_q_reg * k_reg;
    assign nw_prod   = total_reg * wide_reg;

    // bin index of a sample, clamped to the last bin
    assign q_bin = div_quot[BQ_W-1:0];
    always_comb
    begin
        priority if (zr_reg)
            m_next = '0;
        else if (q_bin >= k_reg)
            m_next = TB_W'(k_reg - K_W'(1));
        else
            m_next = TB_W'(q_bin);
    end

    // lower edge, the sum never falls below min so only the top can overflow
    assign edge_sum = {{3{min_reg[SMP_W-1]}}, min_reg} +
                      $signed({2'b00, div_quot[WIDE_W-1:0]});
    assign edge_next = (!edge_sum[SMP_W+2] && (edge_sum[SMP_W+1:SMP_W-1] != '0)) ?
                       $signed(MAX_POS) : edge_sum[SMP_W-1:0];

    always_comb
    begin
        priority if (zr_reg)
            dens_next = (tally_q_reg != '0) ? DENS_SAT : '0;
        else if (div_quot[NUM_W-1:FRAC_W] != '0)
            dens_next = DENS_SAT;
        else
            dens_next = div_quot[SMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            min_reg       <= $signed(MAX_POS);
            max_reg       <= $signed(MIN_NEG);
            bin_count_reg <= K_RESET;
            tally_vld_reg <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= K_W'(1);
            wide_reg      <= '0;
            zr_reg        <= 1'b0;
            j_reg         <= '0;
            i_reg         <= '0;
        end
        else
        begin
            if (cfg_write_en)
                bin_count_reg <= cfg_write_data;

            if (store_we)
            begin
                total_reg <= total_reg + 1'b1;
                if (in_beat.sample_value < min_reg)
                    min_reg <= in_beat.sample_value;
                if (in_beat.sample_value > max_reg)
                    max_reg <= in_beat.sample_value;
            end

            if (cmd.pass_init)
            begin
                k_reg         <= k_next;
                wide_reg      <= wide_next;
                zr_reg        <= (wide_next == '0);
                j_reg         <= '0;
                i_reg         <= '0;
                tally_vld_reg <= '0;
            end

            if (cmd.tally_wr)
                tally_vld_reg[m_reg] <= 1'b1;
            if (cmd.next_smp)
                j_reg <= j_reg + 1'b1;
            if (cmd.next_bin)
                i_reg <= i_reg + 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.pass_end)
            begin
                total_reg <= '0;
                min_reg   <= $signed(MAX_POS);
                max_reg   <= $signed(MIN_NEG);
            end
        end
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (store_we)
            smp_mem[total_reg[AW-1:0]] <= in_beat.sample_value;
        if (cmd.smp_rd)
            smp_rd_reg <= smp_mem[j_reg[AW-1:0]];
    end

    // tallies, an entry not yet written this pass reads as zero
    assign tally_addr = cmd.tally_rd_bin ? m_next : i_reg;
    assign tally_rd   = cmd.tally_rd_bin || cmd.edge_mul;

    always_ff @(posedge clk)
    begin
        if (cmd.tally_wr)
            tally_mem[m_reg] <= tally_q_reg + 1'b1;
        if (tally_rd)
            tally_q_reg <= tally_vld_reg[tally_addr] ? tally_mem[tally_addr] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tally_rd_bin)
            m_reg <= m_next;
        if (cmd.bin_mul)
        begin
            num_reg <= NUM_W'(bin_prod);
            den_reg <= DEN_W'(wide_reg);
        end
        if (cmd.edge_mul)
        begin
            num_reg <= NUM_W'(edge_prod);
            den_reg <= DEN_W'(k_reg);
        end
        if (cmd.dens_mul)
        begin
            edge_reg <= edge_next;
            num_reg  <= {tk_prod, {FRAC_W{1'b0}}};
            den_reg  <= nw_prod;
        end
        if (cmd.out_load)
        begin
            out_beat_reg.bin_number   <= BIN_W'(i_reg);
            out_beat_reg.bin_low_edge <= edge_reg;
            out_beat_reg.bin_density  <= dens_next;
            out_beat_reg.zero_range   <= zr_reg;
            out_beat_reg.last_bin     <= status.bin_last;
        end
    end

    assign status.in_last  = in_beat.last_sample;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.smp_last = (j_reg == total_reg - 1'b1);
    assign status.bin_last = (K_W'(i_reg) == k_reg - K_W'(1));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample total beyond store depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_end |=> (total_reg == '0) && (min_reg == $signed(MAX_POS)) &&
                         (max_reg == $signed(MIN_NEG)))
        else $error("set state not cleared after pass");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (K_W'(i_reg) < k_reg))
        else $error("bin reported beyond bin count");

endmodule
`default_nettype wire

// File: rtl/hde_ctrl.sv
// hde_ctrl: sequencer for load, binning and emit passes
`default_nettype none
module hde_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hde_pkg::dp_status_t status,
    output hde_pkg::dp_cmd_t    cmd
);
    import hde_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.in_last)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.pass_init = 1'b1;
                state_next    = ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.smp_rd = 1'b1;
                state_next = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                cmd.bin_mul = 1'b1;
                state_next  = ST_S_GO;
            end
            ST_S_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_short = 1'b1;
                state_next    = ST_S_WAIT;
            end
            ST_S_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_T_RD;
            end
            ST_T_RD:
            begin
                cmd.tally_rd_bin = 1'b1;
                state_next       = ST_T_WR;
            end
            ST_T_WR:
            begin
                cmd.tally_wr = 1'b1;
                cmd.next_smp = 1'b1;
                state_next   = status.smp_last ? ST_E_MUL : ST_S_RD;
            end
            ST_E_MUL:
            begin
                cmd.edge_mul = 1'b1;
                state_next   = ST_E_GO;
            end
            ST_E_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.dens_mul = 1'b1;
                state_next   = ST_D_GO;
            end
            ST_D_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold the finished bin until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.bin_last)
                    begin
                        cmd.pass_end = 1'b1;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        cmd.next_bin = 1'b1;
                        state_next   = ST_E_MUL;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    assign in_stall = (state_reg != ST_LOAD);

endmodule
`default_nettype wire

// File: rtl/histogram_density_estimator.sv
// histogram_density_estimator: top level of the equal-width histogram density block
//
//  channel  direction  handshake              beat
//  in       sink       in_valid / in_stall    in_beat_t   (sample_value, last_sample)
//  out      source     out_valid / out_stall  out_beat_t  (bin, edge, density, flags)
//  cfg      sink       cfg_write_en           bin_count   (cfg_write_data)
//
// samples load at one beat per cycle until the beat flagged last
// the pass then bins each sample with a 7-bit serial divide
// and each bin with two full NUM_W-bit serial divides, NUM_W = clog2(MAX_SAMPLES+1)+39
// in_stall is high for the whole pass; a stalled result holds the next bin back from loading
// reset leaves the block loading, with bin_count at 16
`default_nettype none
module histogram_density_estimator #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_BINS    = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hde_pkg::in_beat_t       in_beat,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hde_pkg::out_beat_t      out_beat,
    input  logic                    cfg_write_en,
    input  logic [hde_pkg::K_W-1:0] cfg_write_data
);
    import hde_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hde_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BINS    (MAX_BINS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_beat        (in_beat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_beat       (out_beat)
    );

endmodule
`default_nettype wire

// File: sim/tb.sv
// tb: self-checking testbench for the equal-width histogram density estimator
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import hde_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int BIN_LIMIT   = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_beat_t            in_beat;
    logic                out_valid;
    logic                out_stall;
    out_beat_t           out_beat;
    logic                cfg_write_en;
    logic [K_W-1:0]      cfg_write_data;

    // predictor state
    logic signed [SMP_W-1:0] held_samples[$];
    longint                  set_min;
    longint                  set_max;
    logic [K_W-1:0]          bin_setting;
    out_beat_t               pending_bins[$];

    int     mismatches;
    longint cycle_no;
    bit     send_calm;
    bit     recv_calm;
    int     samples_sent;

    histogram_density_estimator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_beat        (in_beat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_beat       (out_beat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("histogram_density_estimator: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error: %s got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // builds the expected bins of a closed set
    task automatic predict_histogram();
        int          k;
        int          n;
        longint      range;
        longint      wide;
        bit          zr;
        int          tally[BIN_LIMIT];
        longint      m;
        longint      edge_v;
        longint      num;
        longint      den;
        longint      dens;
        out_beat_t   r;
        k = int'(bin_setting);
        if (k < 1)
            k = 1;
        if (k > BIN_LIMIT)
            k = BIN_LIMIT;
        n = held_samples.size();
        range = (n > 0 && set_max > set_min) ? set_max - set_min : 0;
        wide = range + (range >>> WIDEN_SHIFT);
        zr = (wide == 0);
        foreach (tally[j])
            tally[j] = 0;
        foreach (held_samples[j])
        begin
            m = 0;
            if (!zr)
            begin
                m = ((longint'(held_samples[j]) - set_min) * k) / wide;
                if (m >= k)
                    m = k - 1;
            end
            tally[m]++;
        end
        for (int i = 0; i < k; i++)
        begin
            edge_v = (n == 0) ? 64'sh7FFF_FFFF : set_min;
            if (!zr)
                edge_v += (wide * i) / k;
            if (edge_v > 64'sh7FFF_FFFF)
                edge_v = 64'sh7FFF_FFFF;
            if (zr)
                dens = (tally[i] > 0) ? 64'hFFFF_FFFF : 0;
            else
            begin
                num = (longint'(tally[i]) * k) <<< FRAC_W;
                den = longint'(n) * wide;
                dens = (den == 0) ? 64'hFFFF_FFFF : num / den;
                if (dens > 64'hFFFF_FFFF)
                    dens = 64'hFFFF_FFFF;
            end
            r.bin_number   = i[BIN_W-1:0];
            r.bin_low_edge = edge_v[SMP_W-1:0];
            r.bin_density  = dens[SMP_W-1:0];
            r.zero_range   = zr;
            r.last_bin     = (i == k - 1);
            pending_bins.push_back(r);
        end
        held_samples.delete();
        set_min = 64'sh7FFF_FFFF;
        set_max = -64'sh8000_0000;
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] value, input bit last);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat.sample_value <= value;
        in_beat.last_sample  <= last;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
        if (held_samples.size() < STORE_DEPTH)
        begin
            held_samples.push_back(value);
            if (longint'($signed(value)) < set_min)
                set_min = longint'($signed(value));
            if (longint'($signed(value)) > set_max)
                set_max = longint'($signed(value));
        end
        if (last)
            predict_histogram();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending_bins.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_bins(input logic [K_W-1:0] k);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= k;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        bin_setting = k;
    endtask

    // random sample from a centre upward, with a spread of 2^bits
    function automatic logic [SMP_W-1:0] near(input logic [SMP_W-1:0] centre, input int bits);
        logic [SMP_W-1:0] d;
        d = $urandom() & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
        return centre + d;
    endfunction

    task automatic send_set(input int n, input int style);
        logic [SMP_W-1:0] centre;
        int               bits;
        centre = $urandom();
        bits = $urandom_range(0, 32);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: send_sample($urandom(), i == n - 1);
                1: send_sample(near(centre, bits), i == n - 1);
                default: send_sample(centre, i == n - 1);
            endcase
        end
    endtask

    task automatic test_defaults();
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0003_8000, 1'b0);
        send_sample(32'hFFFF_0000, 1'b1);
    endtask

    task automatic test_extremes();
        write_bins(7'd64);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        write_bins(7'd1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
    endtask

    task automatic test_zero_range();
        write_bins(7'd5);
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);
    endtask

    // out-of-range settings are clamped by the block
    task automatic test_bin_clamp();
        write_bins(7'd0);
        send_sample(32'h0000_0010, 1'b0);
        send_sample(32'h0000_0020, 1'b1);
        write_bins(7'd127);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0010_0000, 1'b1);
        write_bins(7'd65);
        send_sample(32'hFFFF_FFF0, 1'b0);
        send_sample(32'h0000_0100, 1'b1);
    endtask

    task automatic test_random();
        int target;
        target = samples_sent + 450;
        while (samples_sent < target)
        begin
            if ($urandom_range(0, 2) == 0)
                write_bins(K_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                              : $urandom_range(1, 64)));
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            send_set($urandom_range(1, 20), ($urandom_range(0, 9) == 0) ? 2
                                              : $urandom_range(0, 1));
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    // result side: random stall then take one beat and check it
    initial
    begin
        int        gap;
        out_beat_t want;
        out_stall = 1'b1;
        wait (rst_n);
        forever
        begin
            gap = recv_calm ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_bins.size() == 0)
                report_mismatch("unexpected beat, bin", 64'(out_beat.bin_number), 64'(0));
            else
            begin
                want = pending_bins.pop_front();
                if (out_beat.bin_number !== want.bin_number)
                    report_mismatch("bin_number", 64'(out_beat.bin_number),
                                    64'(want.bin_number));
                if (out_beat.bin_low_edge !== want.bin_low_edge)
                    report_mismatch("bin_low_edge", 64'(unsigned'(out_beat.bin_low_edge)),
                                    64'(unsigned'(want.bin_low_edge)));
                if (out_beat.bin_density !== want.bin_density)
                    report_mismatch("bin_density", 64'(out_beat.bin_density),
                                    64'(want.bin_density));
                if (out_beat.zero_range !== want.zero_range)
                    report_mismatch("zero_range", 64'(out_beat.zero_range),
                                    64'(want.zero_range));
                if (out_beat.last_bin !== want.last_bin)
                    report_mismatch("last_bin", 64'(out_beat.last_bin), 64'(want.last_bin));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        mismatches     = 0;
        cycle_no       = 0;
        send_calm      = 1'b0;
        recv_calm      = 1'b0;
        samples_sent   = 0;
        bin_setting    = K_RESET;
        set_min        = 64'sh7FFF_FFFF;
        set_max        = -64'sh8000_0000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_zero_range();
        test_bin_clamp();
        test_random();

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("histogram_density_estimator: match");
        else
            $display("histogram_density_estimator: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
